// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file ppre_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PPRE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppre assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PPRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppre assertion failed");

`endif

// ===== hw/rtl/ppre_pkg.sv =====
package ppre_pkg;

   localparam int unsigned GPL_W    = 9;
   localparam logic [GPL_W-1:0] GPL_RESET = 9'd40;
   localparam int unsigned X_W      = 12;
   localparam int unsigned Y_W      = 10;
   localparam int unsigned COLOR_W  = 4;
   localparam int unsigned ROP_W    = 4;
   localparam int unsigned POS_W    = 4;
   localparam int unsigned PLANES   = 4;
   localparam int unsigned PLANE_W  = 16;
   localparam int unsigned GROUP_W  = PLANES * PLANE_W;
   localparam int unsigned PROD_W   = Y_W + GPL_W;
   localparam int unsigned GI_W     = PROD_W + 1;
   localparam int unsigned BIDX_W   = 6;

   typedef enum logic {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   typedef enum logic [ROP_W-1:0] {
      ROP_CLEAR     = 4'd0,
      ROP_AND       = 4'd1,
      ROP_AND_NOTD  = 4'd2,
      ROP_SRC       = 4'd3,
      ROP_NOTS_AND  = 4'd4,
      ROP_DST       = 4'd5,
      ROP_XOR       = 4'd6,
      ROP_OR        = 4'd7,
      ROP_NOR       = 4'd8,
      ROP_XNOR      = 4'd9,
      ROP_NOTD      = 4'd10,
      ROP_OR_NOTD   = 4'd11,
      ROP_NOTS      = 4'd12,
      ROP_NOTS_OR   = 4'd13,
      ROP_NAND      = 4'd14,
      ROP_SET       = 4'd15
   } rop_type;

   typedef struct packed {
      cmd_type              cmd;
      rop_type              rop;
      logic [COLOR_W-1:0]   color;
      logic [POS_W-1:0]     pos;
   } pix_ctl_type;

endpackage

// ===== hw/rtl/ppre_merge.sv =====
module ppre_merge
   import ppre_pkg::*;
(
   input  logic [GROUP_W-1:0] group_i,
   input  pix_ctl_type        ctl_i,
   output logic [GROUP_W-1:0] group_o,
   output logic [COLOR_W-1:0] value_o
);

   function automatic logic [COLOR_W-1:0] apply_rop(
      input rop_type            op,
      input logic [COLOR_W-1:0] s,
      input logic [COLOR_W-1:0] d
   );
      logic [COLOR_W-1:0] r;
      unique case (op)
         ROP_CLEAR:    r = '0;
         ROP_AND:      r = s & d;
         ROP_AND_NOTD: r = s & ~d;
         ROP_SRC:      r = s;
         ROP_NOTS_AND: r = ~s & d;
         ROP_DST:      r = d;
         ROP_XOR:      r = s ^ d;
         ROP_OR:       r = s | d;
         ROP_NOR:      r = ~(s | d);
         ROP_XNOR:     r = ~(s ^ d);
         ROP_NOTD:     r = ~d;
         ROP_OR_NOTD:  r = s | ~d;
         ROP_NOTS:     r = ~s;
         ROP_NOTS_OR:  r = ~s | d;
         ROP_NAND:     r = ~(s & d);
         ROP_SET:      r = '1;
         default:      r = '0;
      endcase
      return r;
   endfunction

   logic [COLOR_W-1:0] dst;
   logic [COLOR_W-1:0] res;

   always_comb begin
      logic [BIDX_W-1:0] bidx;
      dst     = '0;
      group_o = group_i;
      for (int p = 0; p < PLANES; p++) begin
         bidx   = {2'(p), ctl_i.pos};
         dst[p] = group_i[bidx];
      end
      res = apply_rop(ctl_i.rop, ctl_i.color, dst);
      for (int p = 0; p < PLANES; p++) begin
         bidx          = {2'(p), ctl_i.pos};
         group_o[bidx] = res[p];
      end
      value_o = (ctl_i.cmd == CMD_WRITE) ? res : dst;
   end

endmodule

// ===== hw/rtl/planar_pixel_rop_engine.sv =====
// channel  | handshake            | beat
// ---------+----------------------+---------------------------------------------
// request  | start, busy          | req_command req_pos_x req_pos_y req_color req_rop
// response | rsp_valid (strobe)   | rsp_pixel_value rsp_out_of_range
// csr      | csr_wr_en            | csr_wr_data (groups_per_line)
//
// One pixel beat per cycle unless busy; rsp_valid is registered after stage 2.
// The group index multiply, the memory read and the merge/write-back each own a stage.
// A write in the last stage forwards its group to the access of that group behind it.
// After reset busy stays high while every group of the store is cleared to zero.
// The receiver cannot stall; rsp_valid is a one-cycle strobe.
module planar_pixel_rop_engine
   import ppre_pkg::*;
#(
   parameter int unsigned STORE_GROUPS = 4096
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [X_W-1:0]     req_pos_x,
   input  logic [Y_W-1:0]     req_pos_y,
   input  logic [COLOR_W-1:0] req_color,
   input  logic [ROP_W-1:0]   req_rop,
   output logic               rsp_valid,
   output logic [COLOR_W-1:0] rsp_pixel_value,
   output logic               rsp_out_of_range,
   input  logic               csr_wr_en,
   input  logic [GPL_W-1:0]   csr_wr_data
);

   localparam int unsigned ADDR_W = $clog2(STORE_GROUPS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_GROUPS - 1);
   localparam logic [GI_W-1:0]   GI_LIMIT  = GI_W'(STORE_GROUPS);

   logic [GROUP_W-1:0] plane_mem_ff [STORE_GROUPS];

   logic [GPL_W-1:0]   gpl_ff, gpl_in;
   logic               clr_active_ff, clr_active_in;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;

   logic               s1_valid_ff, s1_valid_in;
   pix_ctl_type        s1_ctl_ff, s1_ctl_in;
   logic [GI_W-1:0]    s1_gi_ff, s1_gi_in;

   logic               s2_valid_ff, s2_valid_in;
   pix_ctl_type        s2_ctl_ff;
   logic               s2_oor_ff, s2_oor_in;
   logic [ADDR_W-1:0]  s2_addr_ff;
   logic [GROUP_W-1:0] rd_data_ff;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [GROUP_W-1:0] fwd_data_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_oor_ff, rsp_oor_in;

   logic               accept;
   logic [PROD_W-1:0]  row_base;
   logic [ADDR_W-1:0]  s1_addr;
   logic               s2_wr;
   logic [GROUP_W-1:0] s2_group;
   logic [GROUP_W-1:0] new_group;
   logic [COLOR_W-1:0] new_value;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [GROUP_W-1:0] mem_wdata;

   assign accept   = start & ~clr_active_ff;
   assign row_base = PROD_W'(req_pos_y) * PROD_W'(gpl_ff);
   assign s1_addr  = s1_gi_ff[ADDR_W-1:0];
   assign s2_wr    = s2_valid_ff & (s2_ctl_ff.cmd == CMD_WRITE) & ~s2_oor_ff;
   assign s2_group = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

   ppre_merge u_merge (
      .group_i (s2_group),
      .ctl_i   (s2_ctl_ff),
      .group_o (new_group),
      .value_o (new_value)
   );

   always_comb begin
      gpl_in        = csr_wr_en ? csr_wr_data : gpl_ff;
      clr_active_in = clr_active_ff & (clr_cnt_ff != LAST_ADDR);
      clr_cnt_in    = clr_active_ff ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

      s1_valid_in     = accept;
      s1_ctl_in.cmd   = cmd_type'(req_command);
      s1_ctl_in.rop   = rop_type'(req_rop);
      s1_ctl_in.color = req_color;
      s1_ctl_in.pos   = ~req_pos_x[POS_W-1:0];
      s1_gi_in        = GI_W'(req_pos_x[X_W-1:POS_W]) + GI_W'(row_base);

      s2_valid_in = s1_valid_ff;
      s2_oor_in   = s1_gi_ff >= GI_LIMIT;
      fwd_hit_in  = s2_wr & (s1_addr == s2_addr_ff);

      rsp_valid_in = s2_valid_ff;
      rsp_value_in = s2_oor_ff ? '0 : new_value;
      rsp_oor_in   = s2_oor_ff;

      mem_we    = clr_active_ff | s2_wr;
      mem_waddr = clr_active_ff ? clr_cnt_ff : s2_addr_ff;
      mem_wdata = clr_active_ff ? '0 : new_group;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpl_ff        <= GPL_RESET;
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fwd_hit_ff    <= 1'b0;
      end else begin
         gpl_ff        <= gpl_in;
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fwd_hit_ff    <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff    <= s1_ctl_in;
      s1_gi_ff     <= s1_gi_in;
      s2_ctl_ff    <= s1_ctl_ff;
      s2_oor_ff    <= s2_oor_in;
      s2_addr_ff   <= s1_addr;
      fwd_data_ff  <= new_group;
      rsp_value_ff <= rsp_value_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         plane_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= plane_mem_ff[s1_addr];
   end

   assign busy             = clr_active_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_value  = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

// ===== hw/rtl/ppre_checker.sv =====
`include "assert_macros.svh"

module ppre_checker
   import ppre_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [COLOR_W-1:0] rsp_pixel_value,
   input logic               rsp_out_of_range
);

   `PPRE_ASSERT_IMPL(a_rsp_latency, clock, reset, start && !busy, ##3 rsp_valid)
   `PPRE_ASSERT_IMPL(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, 3))
   `PPRE_ASSERT_IMPL(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range, rsp_pixel_value == '0)
   `PPRE_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, busy)
   `PPRE_ASSERT_IMPL(a_no_rsp_clearing, clock, reset, busy, !rsp_valid)

endmodule

bind planar_pixel_rop_engine ppre_checker u_ppre_checker (.*);

// ===== tb/ppre_pixel_checker.sv =====
`timescale 1ns / 1ps

module ppre_pixel_checker
   import ppre_pkg::*;
#(
   parameter int unsigned STORE_GROUPS = 4096
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_command,
   input  logic [X_W-1:0]     req_pos_x,
   input  logic [Y_W-1:0]     req_pos_y,
   input  logic [COLOR_W-1:0] req_color,
   input  logic [ROP_W-1:0]   req_rop,
   input  logic               rsp_valid,
   input  logic [COLOR_W-1:0] rsp_pixel_value,
   input  logic               rsp_out_of_range,
   input  logic               csr_wr_en,
   input  logic [GPL_W-1:0]   csr_wr_data,
   output int unsigned        error_count,
   output int unsigned        pending_count
);

   typedef struct packed {
      logic [COLOR_W-1:0] pixel_value;
      logic               out_of_range;
   } pixel_outcome_type;

   logic [GROUP_W-1:0] frame_groups [STORE_GROUPS];
   logic [GPL_W-1:0]   line_groups;
   pixel_outcome_type  expected_pixels [$];
   int unsigned        mismatches;

   initial begin
      error_count   = 0;
      pending_count = 0;
      mismatches    = 0;
      line_groups   = GPL_RESET;
   end

   function automatic logic [COLOR_W-1:0] rop_combine(input rop_type op,
                                                      input logic [COLOR_W-1:0] s,
                                                      input logic [COLOR_W-1:0] d);
      case (op)
         ROP_CLEAR:    return '0;
         ROP_AND:      return s & d;
         ROP_AND_NOTD: return s & ~d;
         ROP_SRC:      return s;
         ROP_NOTS_AND: return ~s & d;
         ROP_DST:      return d;
         ROP_XOR:      return s ^ d;
         ROP_OR:       return s | d;
         ROP_NOR:      return ~(s | d);
         ROP_XNOR:     return ~(s ^ d);
         ROP_NOTD:     return ~d;
         ROP_OR_NOTD:  return s | ~d;
         ROP_NOTS:     return ~s;
         ROP_NOTS_OR:  return ~s | d;
         ROP_NAND:     return ~(s & d);
         default:      return '1;
      endcase
   endfunction

   function automatic pixel_outcome_type paint_pixel(input cmd_type cmd,
                                                     input logic [X_W-1:0] x,
                                                     input logic [Y_W-1:0] y,
                                                     input logic [COLOR_W-1:0] color,
                                                     input rop_type op);
      pixel_outcome_type  res;
      int unsigned        gi;
      int unsigned        pos;
      int unsigned        p;
      logic [COLOR_W-1:0] dst;
      res = '0;
      gi  = int'(x[X_W-1:POS_W]) + int'(y) * int'(line_groups);
      if (gi >= STORE_GROUPS) begin
         res.out_of_range = 1'b1;
      end else begin
         pos = (PLANE_W - 1) - int'(x[POS_W-1:0]);
         for (p = 0; p < PLANES; p++)
            dst[p] = frame_groups[gi][PLANE_W*p + pos];
         if (cmd == CMD_READ) begin
            res.pixel_value = dst;
         end else begin
            res.pixel_value = rop_combine(op, color, dst);
            for (p = 0; p < PLANES; p++)
               frame_groups[gi][PLANE_W*p + pos] = res.pixel_value[p];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      pixel_outcome_type want;
      if (reset) begin
         expected_pixels.delete();
         foreach (frame_groups[i])
            frame_groups[i] = '0;
         line_groups = GPL_RESET;
      end else begin
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               if (mismatches < 10)
                  $display("pixel beat with nothing pending: value %0d oor %0b",
                           rsp_pixel_value, rsp_out_of_range);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_value !== want.pixel_value ||
                   rsp_out_of_range !== want.out_of_range) begin
                  if (mismatches < 10)
                     $display("pixel mismatch: expected value %0d oor %0b, got value %0d oor %0b",
                              want.pixel_value, want.out_of_range,
                              rsp_pixel_value, rsp_out_of_range);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            expected_pixels.push_back(paint_pixel(cmd_type'(req_command), req_pos_x,
                                                  req_pos_y, req_color,
                                                  rop_type'(req_rop)));
         if (csr_wr_en)
            line_groups = csr_wr_data;
      end
      error_count   <= mismatches;
      pending_count <= expected_pixels.size();
   end

endmodule

// ===== tb/planar_pixel_rop_engine_test.sv =====
`timescale 1ns / 1ps

module planar_pixel_rop_engine_test
   import ppre_pkg::*;
();

   localparam int unsigned STORE_GROUPS = 4096;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_command = 1'b0;
   logic [X_W-1:0]     req_pos_x = '0;
   logic [Y_W-1:0]     req_pos_y = '0;
   logic [COLOR_W-1:0] req_color = '0;
   logic [ROP_W-1:0]   req_rop = '0;
   logic               rsp_valid;
   logic [COLOR_W-1:0] rsp_pixel_value;
   logic               rsp_out_of_range;
   logic               csr_wr_en = 1'b0;
   logic [GPL_W-1:0]   csr_wr_data = '0;
   int unsigned        error_count;
   int unsigned        pending_count;
   int unsigned        cycle_count = 0;
   logic [GPL_W-1:0]   line_groups = GPL_RESET;

   planar_pixel_rop_engine #(.STORE_GROUPS(STORE_GROUPS)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_color        (req_color),
      .req_rop          (req_rop),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   ppre_pixel_checker #(.STORE_GROUPS(STORE_GROUPS)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_color        (req_color),
      .req_rop          (req_rop),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_pixel(input cmd_type cmd, input logic [X_W-1:0] x,
                             input logic [Y_W-1:0] y, input logic [COLOR_W-1:0] color,
                             input rop_type op);
      start       <= 1'b1;
      req_command <= cmd;
      req_pos_x   <= x;
      req_pos_y   <= y;
      req_color   <= color;
      req_rop     <= op;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_gap(input int unsigned idle_pct);
      int unsigned n;
      n = 0;
      while ($urandom_range(99, 0) < idle_pct)
         n++;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain_pixels();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic send_random_pixel();
      int unsigned        pick;
      int unsigned        ymax;
      logic [X_W-1:0]     x;
      logic [Y_W-1:0]     y;
      pick = $urandom_range(99, 0);
      if (pick < 65) begin
         // keep to a small window so reads and writes keep hitting the same groups
         x = X_W'($urandom_range(63, 0));
         y = Y_W'($urandom_range(7, 0));
      end else if (pick < 90) begin
         ymax = (line_groups == 0) ? 1023 : (STORE_GROUPS - 1) / line_groups;
         if (ymax > 1023)
            ymax = 1023;
         x = X_W'($urandom_range(4095, 0));
         y = Y_W'($urandom_range(ymax, 0));
      end else begin
         x = X_W'($urandom_range(4095, 0));
         y = Y_W'($urandom_range(1023, 0));
      end
      send_pixel(cmd_type'($urandom_range(1, 0)), x, y, COLOR_W'($urandom_range(15, 0)),
                 rop_type'($urandom_range(15, 0)));
   endtask

   task automatic run_phase(input logic [GPL_W-1:0] gpl, input int unsigned idle_pct,
                            input int unsigned beats);
      drain_pixels();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= gpl;
      line_groups = gpl;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      for (int unsigned i = 0; i < beats; i++) begin
         send_random_pixel();
         if ($urandom_range(59, 0) == 0)
            drain_pixels();
         else
            hold_gap(idle_pct);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_pixel(CMD_WRITE, 12'd17, 10'd0, 4'd3, ROP_SRC);
      for (int unsigned op = 0; op < 16; op++)
         send_pixel(CMD_WRITE, 12'd17, 10'd0, 4'd5, rop_type'(op));
      send_pixel(CMD_READ, 12'd17, 10'd0, 4'd0, ROP_SET);
      send_pixel(CMD_WRITE, 12'd255, 10'd102, 4'd0, ROP_SET);
      send_pixel(CMD_READ, 12'd255, 10'd102, 4'd0, ROP_CLEAR);
      send_pixel(CMD_WRITE, 12'd256, 10'd102, 4'd15, ROP_SET);
      send_pixel(CMD_READ, 12'd4095, 10'd1023, 4'd15, ROP_CLEAR);
      send_pixel(CMD_READ, 12'd4095, 10'd0, 4'd0, ROP_CLEAR);
      send_pixel(CMD_WRITE, 12'd4095, 10'd0, 4'd10, ROP_NOTS);
      send_pixel(CMD_READ, 12'd4080, 10'd0, 4'd0, ROP_CLEAR);

      run_phase(9'd1,   0,  150);
      run_phase(9'd256, 80, 150);
      run_phase(9'd0,   0,  100);
      run_phase(9'd511, 21, 150);
      run_phase(9'd100, 21, 100);
      run_phase(9'd3,   80, 100);

      drain_pixels();
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
